// File: rtl/picsl_pkg.sv
// Shared types and constants of the point-in-closed-surface labeler.
package picsl_pkg;

    localparam int TRI_INDEX_W = 8;
    localparam int LABEL_W     = 16;
    localparam int CROSS_W     = 9;
    localparam int TCOUNT_W    = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_TRIANGLE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INSIDE_LABEL   = 2'd1;

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_WR,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

// File: rtl/picsl_ifs.sv
// Channel interfaces of the point-in-closed-surface labeler.
interface picsl_in_if #(parameter int COORD_BITS = 20);
    import picsl_pkg::*;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [TRI_INDEX_W-1:0]       tri_index;
    logic signed [COORD_BITS-1:0] v1x;
    logic signed [COORD_BITS-1:0] v1y;
    logic signed [COORD_BITS-1:0] v1z;
    logic signed [COORD_BITS-1:0] v2x;
    logic signed [COORD_BITS-1:0] v2y;
    logic signed [COORD_BITS-1:0] v2z;
    logic signed [COORD_BITS-1:0] v3x;
    logic signed [COORD_BITS-1:0] v3y;
    logic signed [COORD_BITS-1:0] v3z;
    logic [LABEL_W-1:0]           node_label;
    modport source(output valid, func, tri_index, v1x, v1y, v1z, v2x, v2y, v2z,
                   v3x, v3y, v3z, node_label, input ready);
    modport sink(input valid, func, tri_index, v1x, v1y, v1z, v2x, v2y, v2z,
                 v3x, v3y, v3z, node_label, output ready);
endinterface

interface picsl_out_if;
    import picsl_pkg::*;
    logic               valid;
    logic               ready;
    logic               is_inside;
    logic [LABEL_W-1:0] new_label;
    logic [CROSS_W-1:0] crossings;
    modport source(output valid, is_inside, new_label, crossings, input ready);
    modport sink(input valid, is_inside, new_label, crossings, output ready);
endinterface

interface picsl_cfg_if;
    import picsl_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    modport source(output valid, idx, data, input ready);
    modport sink(input valid, idx, data, output ready);
endinterface

// File: rtl/point_in_closed_surface_labeler.sv
// Top level of the point-in-closed-surface labeler (ray casting along +x).
//
// A load word (func = 0) stores one surface triangle at tri_index: its three
// vertices and its plane normal a, b, c, found with six multipliers in the
// steps accept, multiply, write. The plane offset is never stored:
// the distance numerator is taken as a*(px-x1) + b*(py-y1) + c*(pz-z1),
// which is exact. A classify word (func = 1) walks triangles
// 0 .. min(triangle_count, MAX_TRIANGLES)-1, reading one triangle a cycle
// from the triangle RAM into a fixed pipeline: numerator, a COORD_BITS-stage
// restoring divider for the hit x coordinate, projection onto the dominant
// plane and the exact edge test by cross-multiplication. Hits are counted at
// the pipeline end; an odd count gives inside_label, else node_label passes.
// The RAM read port sets the rate of one triangle per cycle, and the divider
// is the longest part of the pipeline. One word is worked on at a time; a
// finished result sits in an output register, so the next word is accepted
// while it waits. The triangle RAM has no reset and no clearing pass:
// entries must be loaded before a classify word reaches them. Configuration
// is taken at any time and must be written only while the block is idle.
module point_in_closed_surface_labeler #(
    parameter int MAX_TRIANGLES = 256,
    parameter int COORD_BITS    = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    picsl_in_if.sink    i_in,
    picsl_out_if.source o_res,
    picsl_cfg_if.sink   i_cfg
);
    import picsl_pkg::*;

    localparam int CW     = COORD_BITS;
    localparam int IW     = $clog2(MAX_TRIANGLES);
    localparam int CNTW   = $clog2(MAX_TRIANGLES + 1);
    localparam int DW     = CW + 1;
    localparam int AW     = 2 * CW + 2;
    localparam int LW     = CW + 1;
    localparam int HW     = AW - LW;
    localparam int PLW    = LW + 1 + DW;
    localparam int PHW    = HW + DW;
    localparam int NW     = 3 * CW + 5;
    localparam int UW     = CW + 1;
    localparam int EW     = CW + 2;
    localparam int MW     = 2 * EW;
    localparam int PW2    = MW + 1;
    localparam int SL     = CW + 3;
    localparam int SH     = PW2 - SL;
    localparam int QLW    = SL + 1 + EW;
    localparam int QHW    = SH + EW;
    localparam int RW     = PW2 + EW + 2;
    localparam int DV0    = 5;
    localparam int NSTAGE = DV0 + CW + 8;

    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] x3;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] y2;
        logic signed [CW-1:0] y3;
        logic signed [CW-1:0] z1;
        logic signed [CW-1:0] z2;
        logic signed [CW-1:0] z3;
        logic signed [AW-1:0] a;
        logic signed [AW-1:0] b;
        logic signed [AW-1:0] c;
    } t_tri;

    // projected triangle and point, carried down the pipeline
    typedef struct packed {
        logic signed [CW-1:0] u1;
        logic signed [CW-1:0] u2;
        logic signed [CW-1:0] u3;
        logic signed [CW-1:0] v1;
        logic signed [CW-1:0] v2;
        logic signed [CW-1:0] v3;
        logic signed [CW-1:0] ups;
        logic signed [CW-1:0] vp;
        logic signed [CW-1:0] px;
        logic                 use_xh;
    } t_geo;

    // ---------------- control ----------------
    t_state r_state, n_state;
    logic   in_ready, issue, out_load, ld_in_range;

    logic [TCOUNT_W-1:0] r_tcount;
    logic [LABEL_W-1:0]  r_inside_label;
    logic [IW-1:0]       r_issue, r_nlast, n_nlast;
    logic [CNTW-1:0]     r_count;
    logic [NSTAGE-1:0]   r_vpipe;
    logic                r_hit;

    logic [IW+TRI_INDEX_W-1:0] ld_idx_w;
    logic [IW+TCOUNT_W:0]      tc_w;

    logic               r_out_valid, r_out_inside;
    logic [LABEL_W-1:0] r_out_label;
    logic [CROSS_W-1:0] r_out_cross;
    logic [CNTW+CROSS_W-1:0] cnt_w;

    // accepted word
    logic signed [CW-1:0] r_px, r_py, r_pz, r_v2x, r_v2y, r_v2z, r_v3x, r_v3y, r_v3z;
    logic [LABEL_W-1:0]   r_label;
    logic [IW-1:0]        r_widx;

    // load path
    logic signed [DW-1:0] ld_dx2, ld_dy2, ld_dz2, ld_dx3, ld_dy3, ld_dz3;
    logic signed [AW-1:0] r_lp1, r_lp2, r_lp3, r_lp4, r_lp5, r_lp6;
    t_tri                 wr_tri, rd_tri;
    logic                 ram_we;
    logic [$bits(t_tri)-1:0] ram_rdata;

    assign ld_idx_w    = (IW + TRI_INDEX_W)'(i_in.tri_index);
    assign ld_in_range = ld_idx_w < (IW + TRI_INDEX_W)'(MAX_TRIANGLES);
    assign tc_w        = (IW + TCOUNT_W + 1)'(r_tcount);
    assign cnt_w       = (CNTW + CROSS_W)'(r_count);

    always_comb begin
        if (tc_w >= (IW + TCOUNT_W + 1)'(MAX_TRIANGLES)) begin
            n_nlast = IW'(MAX_TRIANGLES - 1);
        end else begin
            n_nlast = IW'(tc_w - 1'b1);
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.func == FUNC_LOAD) begin
                        if (ld_in_range) begin
                            n_state = ST_LD_MUL;
                        end
                    end else if (r_tcount == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_LD_MUL: n_state = ST_LD_WR;
            ST_LD_WR:  n_state = ST_IDLE;
            ST_RUN: begin
                issue = 1'b1;
                if (r_issue == r_nlast) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the last triangle to drain and the output to free up
                if (r_vpipe == '0 && (!r_out_valid || o_res.ready)) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcount       <= '0;
            r_inside_label <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                REG_TRIANGLE_COUNT: r_tcount       <= i_cfg.data[TCOUNT_W-1:0];
                REG_INSIDE_LABEL:   r_inside_label <= i_cfg.data[LABEL_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the accepted word
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_px    <= i_in.v1x;
            r_py    <= i_in.v1y;
            r_pz    <= i_in.v1z;
            r_v2x   <= i_in.v2x;
            r_v2y   <= i_in.v2y;
            r_v2z   <= i_in.v2z;
            r_v3x   <= i_in.v3x;
            r_v3y   <= i_in.v3y;
            r_v3z   <= i_in.v3z;
            r_label <= i_in.node_label;
            r_widx  <= ld_idx_w[IW-1:0];
            r_nlast <= n_nlast;
        end
    end

    // issue counter, valid shift line and hit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= '0;
            r_vpipe <= '0;
            r_count <= '0;
        end else begin
            r_vpipe <= {r_vpipe[NSTAGE-2:0], issue};
            if (in_ready && i_in.valid) begin
                r_issue <= '0;
                r_count <= '0;
            end else begin
                if (issue) begin
                    r_issue <= r_issue + 1'b1;
                end
                if (r_vpipe[NSTAGE-1] && r_hit) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_inside <= r_count[0];
            r_out_label  <= r_count[0] ? r_inside_label : r_label;
            r_out_cross  <= cnt_w[CROSS_W-1:0];
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.is_inside = r_out_inside;
    assign o_res.new_label = r_out_label;
    assign o_res.crossings = r_out_cross;

    // ---------------- triangle load: normal = (v2-v1) x (v3-v1) ----------------
    assign ld_dx2 = DW'(r_v2x) - DW'(r_px);
    assign ld_dy2 = DW'(r_v2y) - DW'(r_py);
    assign ld_dz2 = DW'(r_v2z) - DW'(r_pz);
    assign ld_dx3 = DW'(r_v3x) - DW'(r_px);
    assign ld_dy3 = DW'(r_v3y) - DW'(r_py);
    assign ld_dz3 = DW'(r_v3z) - DW'(r_pz);

    always_ff @(posedge i_clk) begin
        r_lp1 <= ld_dy2 * ld_dz3;
        r_lp2 <= ld_dz2 * ld_dy3;
        r_lp3 <= ld_dz2 * ld_dx3;
        r_lp4 <= ld_dx2 * ld_dz3;
        r_lp5 <= ld_dx2 * ld_dy3;
        r_lp6 <= ld_dy2 * ld_dx3;
    end

    always_comb begin
        wr_tri.x1 = r_px;
        wr_tri.x2 = r_v2x;
        wr_tri.x3 = r_v3x;
        wr_tri.y1 = r_py;
        wr_tri.y2 = r_v2y;
        wr_tri.y3 = r_v3y;
        wr_tri.z1 = r_pz;
        wr_tri.z2 = r_v2z;
        wr_tri.z3 = r_v3z;
        wr_tri.a  = r_lp1 - r_lp2;
        wr_tri.b  = r_lp3 - r_lp4;
        wr_tri.c  = r_lp5 - r_lp6;
    end

    assign ram_we = (r_state == ST_LD_WR);

    picsl_ram #(
        .WIDTH($bits(t_tri)),
        .DEPTH(MAX_TRIANGLES)
    ) u_tri_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_widx),
        .i_wdata(wr_tri),
        .i_raddr(r_issue),
        .o_rdata(ram_rdata)
    );

    assign rd_tri = t_tri'(ram_rdata);

    // ---------------- S1: offsets, magnitudes, projection ----------------
    logic signed [DW-1:0] s1_dx, s1_dy, s1_dz;
    logic [AW-1:0]        s1_absa, s1_absb, s1_absc;
    logic                 s1_yz, s1_xz;
    t_geo                 s1_geo;

    logic signed [AW-1:0] r_s1_a, r_s1_b, r_s1_c;
    logic signed [DW-1:0] r_s1_dx, r_s1_dy, r_s1_dz;
    logic [AW-1:0]        r_s1_absa;
    logic                 r_s1_live;
    t_geo                 r_s1_geo;

    always_comb begin
        s1_dx   = DW'(r_px) - DW'(rd_tri.x1);
        s1_dy   = DW'(r_py) - DW'(rd_tri.y1);
        s1_dz   = DW'(r_pz) - DW'(rd_tri.z1);
        s1_absa = rd_tri.a[AW-1] ? AW'(-rd_tri.a) : AW'(rd_tri.a);
        s1_absb = rd_tri.b[AW-1] ? AW'(-rd_tri.b) : AW'(rd_tri.b);
        s1_absc = rd_tri.c[AW-1] ? AW'(-rd_tri.c) : AW'(rd_tri.c);
        s1_yz   = (s1_absa > s1_absb) && (s1_absa > s1_absc);
        s1_xz   = !s1_yz && (s1_absb > s1_absc);
        s1_geo.px  = r_px;
        s1_geo.ups = r_py;
        if (s1_yz) begin
            s1_geo.u1 = rd_tri.y1;
            s1_geo.u2 = rd_tri.y2;
            s1_geo.u3 = rd_tri.y3;
            s1_geo.use_xh = 1'b0;
        end else begin
            s1_geo.u1 = rd_tri.x1;
            s1_geo.u2 = rd_tri.x2;
            s1_geo.u3 = rd_tri.x3;
            s1_geo.use_xh = 1'b1;
        end
        if (s1_yz || s1_xz) begin
            s1_geo.v1 = rd_tri.z1;
            s1_geo.v2 = rd_tri.z2;
            s1_geo.v3 = rd_tri.z3;
            s1_geo.vp = r_pz;
        end else begin
            s1_geo.v1 = rd_tri.y1;
            s1_geo.v2 = rd_tri.y2;
            s1_geo.v3 = rd_tri.y3;
            s1_geo.vp = r_py;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_a    <= rd_tri.a;
        r_s1_b    <= rd_tri.b;
        r_s1_c    <= rd_tri.c;
        r_s1_dx   <= s1_dx;
        r_s1_dy   <= s1_dy;
        r_s1_dz   <= s1_dz;
        r_s1_absa <= s1_absa;
        // drop triangles nearly parallel to the ray
        r_s1_live <= r_vpipe[0] && (s1_absa > AW'(1));
        r_s1_geo  <= s1_geo;
    end

    // ---------------- S2: partial products of the numerator ----------------
    logic signed [PLW-1:0] r_s2_pal, r_s2_pbl, r_s2_pcl;
    logic signed [PHW-1:0] r_s2_pah, r_s2_pbh, r_s2_pch;
    logic                  r_s2_aneg, r_s2_live;
    logic [AW-1:0]         r_s2_absa;
    t_geo                  r_s2_geo;

    always_ff @(posedge i_clk) begin
        r_s2_pal  <= $signed({1'b0, r_s1_a[LW-1:0]}) * r_s1_dx;
        r_s2_pah  <= $signed(r_s1_a[AW-1:LW]) * r_s1_dx;
        r_s2_pbl  <= $signed({1'b0, r_s1_b[LW-1:0]}) * r_s1_dy;
        r_s2_pbh  <= $signed(r_s1_b[AW-1:LW]) * r_s1_dy;
        r_s2_pcl  <= $signed({1'b0, r_s1_c[LW-1:0]}) * r_s1_dz;
        r_s2_pch  <= $signed(r_s1_c[AW-1:LW]) * r_s1_dz;
        r_s2_aneg <= r_s1_a[AW-1];
        r_s2_absa <= r_s1_absa;
        r_s2_live <= r_s1_live;
        r_s2_geo  <= r_s1_geo;
    end

    // ---------------- S3: products, S3b: numerator ----------------
    logic signed [NW-1:0] r_s3_ta, r_s3_tb, r_s3_tc, r_s3b_num;
    logic                 r_s3_aneg, r_s3_live, r_s3b_aneg, r_s3b_live;
    logic [AW-1:0]        r_s3_absa, r_s3b_absa;
    t_geo                 r_s3_geo, r_s3b_geo;

    always_ff @(posedge i_clk) begin
        r_s3_ta    <= (NW'(r_s2_pah) <<< LW) + NW'(r_s2_pal);
        r_s3_tb    <= (NW'(r_s2_pbh) <<< LW) + NW'(r_s2_pbl);
        r_s3_tc    <= (NW'(r_s2_pch) <<< LW) + NW'(r_s2_pcl);
        r_s3_aneg  <= r_s2_aneg;
        r_s3_absa  <= r_s2_absa;
        r_s3_live  <= r_s2_live;
        r_s3_geo   <= r_s2_geo;
        r_s3b_num  <= r_s3_ta + r_s3_tb + r_s3_tc;
        r_s3b_aneg <= r_s3_aneg;
        r_s3b_absa <= r_s3_absa;
        r_s3b_live <= r_s3_live;
        r_s3b_geo  <= r_s3_geo;
    end

    // ---------------- S4 + divider: q = |num| / |a|, clamped ----------------
    logic                 s4_behind, s4_sat;
    logic [NW-1:0]        s4_absnum;
    logic [NW-1:0]        r_dv_rem  [CW+1];
    logic [AW-1:0]        r_dv_den  [CW+1];
    logic [CW-1:0]        r_dv_q    [CW+1];
    logic                 r_dv_sat  [CW+1];
    logic                 r_dv_live [CW+1];
    t_geo                 r_dv_geo  [CW+1];
    logic [NW-1:0]        dv_shd    [CW];
    logic                 dv_ge     [CW];

    always_comb begin
        // the hit lies behind the point when num and a share a nonzero sign
        s4_behind = (r_s3b_num != '0) && (r_s3b_num[NW-1] == r_s3b_aneg);
        s4_absnum = r_s3b_num[NW-1] ? NW'(-r_s3b_num) : NW'(r_s3b_num);
        s4_sat    = s4_absnum >= (NW'(r_s3b_absa) << CW);
        for (int k = 0; k < CW; k++) begin
            dv_shd[k] = NW'(r_dv_den[k]) << (CW - 1 - k);
            dv_ge[k]  = r_dv_rem[k] >= dv_shd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_rem[0]  <= s4_absnum;
        r_dv_den[0]  <= r_s3b_absa;
        r_dv_q[0]    <= '0;
        r_dv_sat[0]  <= s4_sat;
        r_dv_live[0] <= r_s3b_live && !s4_behind;
        r_dv_geo[0]  <= r_s3b_geo;
        for (int k = 0; k < CW; k++) begin
            r_dv_rem[k+1]  <= dv_ge[k] ? r_dv_rem[k] - dv_shd[k] : r_dv_rem[k];
            r_dv_q[k+1]    <= r_dv_q[k] | (CW'(dv_ge[k]) << (CW - 1 - k));
            r_dv_den[k+1]  <= r_dv_den[k];
            r_dv_sat[k+1]  <= r_dv_sat[k];
            r_dv_live[k+1] <= r_dv_live[k];
            r_dv_geo[k+1]  <= r_dv_geo[k];
        end
    end

    // ---------------- H0: hit x, saturated one LSB past any vertex ----------------
    logic signed [CW+1:0] h0_xs;
    logic signed [UW-1:0] h0_up, r_h0_up;
    logic signed [CW+1:0] h0_lim;
    logic                 r_h0_live;
    t_geo                 r_h0_geo, dvo_geo;

    assign dvo_geo = r_dv_geo[CW];
    assign h0_lim  = (CW + 2)'(1) <<< (CW - 1);

    always_comb begin
        h0_xs = (CW + 2)'(dvo_geo.px) + $signed({2'b00, r_dv_q[CW]});
        if (!dvo_geo.use_xh) begin
            h0_up = UW'(dvo_geo.ups);
        end else if (r_dv_sat[CW] || h0_xs > h0_lim) begin
            h0_up = UW'(h0_lim);
        end else begin
            h0_up = UW'(h0_xs);
        end
    end

    always_ff @(posedge i_clk) begin
        r_h0_up   <= h0_up;
        r_h0_live <= r_dv_live[CW];
        r_h0_geo  <= dvo_geo;
    end

    // ---------------- H1: edge differences and first products ----------------
    logic signed [EW-1:0] h1_du, h1_dv, h1_a1, h1_b1, h1_a2, h1_b2, h1_e2u, h1_e1v;
    logic signed [MW-1:0] r_h1_m1, r_h1_m2, r_h1_m3, r_h1_m4;
    logic signed [EW-1:0] r_h1_du, r_h1_dv, r_h1_b2, r_h1_e2u, r_h1_e1v, r_h1_a1;
    logic                 r_h1_live;

    always_comb begin
        h1_du  = EW'(r_h0_geo.u3) - EW'(r_h0_geo.u2);
        h1_dv  = EW'(r_h0_geo.v3) - EW'(r_h0_geo.v2);
        h1_a1  = EW'(r_h0_geo.vp) - EW'(r_h0_geo.v1);
        h1_b1  = EW'(r_h0_geo.u1) - EW'(r_h0_up);
        h1_a2  = EW'(r_h0_geo.v2) - EW'(r_h0_geo.v1);
        h1_b2  = EW'(r_h0_geo.u1) - EW'(r_h0_geo.u2);
        h1_e2u = EW'(r_h0_up) - EW'(r_h0_geo.u1);
        h1_e1v = EW'(r_h0_geo.v1) - EW'(r_h0_geo.v2);
    end

    always_ff @(posedge i_clk) begin
        r_h1_m1   <= h1_a1 * h1_du;
        r_h1_m2   <= h1_b1 * h1_dv;
        r_h1_m3   <= h1_a2 * h1_du;
        r_h1_m4   <= h1_b2 * h1_dv;
        r_h1_du   <= h1_du;
        r_h1_dv   <= h1_dv;
        r_h1_b2   <= h1_b2;
        r_h1_e2u  <= h1_e2u;
        r_h1_e1v  <= h1_e1v;
        r_h1_a1   <= h1_a1;
        r_h1_live <= r_h0_live;
    end

    // ---------------- H2: determinant, edge parameter check, branch ----------------
    logic signed [PW2-1:0] h2_den, h2_nr, r_h2_den, r_h2_nr;
    logic                  h2_reject;
    logic signed [EW-1:0]  h2_e1, h2_e2, h2_e3, r_h2_e1, r_h2_e2, r_h2_e3;
    logic                  r_h2_live;

    always_comb begin
        h2_den    = PW2'(r_h1_m1) + PW2'(r_h1_m2);
        h2_nr     = PW2'(r_h1_m3) + PW2'(r_h1_m4);
        h2_reject = (h2_den == '0) || (h2_den > 0 ? h2_nr < h2_den : h2_nr > h2_den);
        if (r_h1_du != '0) begin
            h2_e1 = r_h1_b2;
            h2_e2 = r_h1_e2u;
            h2_e3 = r_h1_du;
        end else begin
            h2_e1 = r_h1_e1v;
            h2_e2 = r_h1_a1;
            h2_e3 = r_h1_dv;
        end
        // degenerate edge 2-3: no crossing
        if (r_h1_du == '0 && r_h1_dv == '0) begin
            h2_reject = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h2_den  <= h2_den;
        r_h2_nr   <= h2_nr;
        r_h2_e1   <= h2_e1;
        r_h2_e2   <= h2_e2;
        r_h2_e3   <= h2_e3;
        r_h2_live <= r_h1_live && !h2_reject;
    end

    // ---------------- H3: partial products of n and d ----------------
    logic signed [QLW-1:0] r_h3_dl1, r_h3_nl2, r_h3_dl3;
    logic signed [QHW-1:0] r_h3_dh1, r_h3_nh2, r_h3_dh3;
    logic                  r_h3_live;

    always_ff @(posedge i_clk) begin
        r_h3_dl1  <= $signed({1'b0, r_h2_den[SL-1:0]}) * r_h2_e1;
        r_h3_dh1  <= $signed(r_h2_den[PW2-1:SL]) * r_h2_e1;
        r_h3_nl2  <= $signed({1'b0, r_h2_nr[SL-1:0]}) * r_h2_e2;
        r_h3_nh2  <= $signed(r_h2_nr[PW2-1:SL]) * r_h2_e2;
        r_h3_dl3  <= $signed({1'b0, r_h2_den[SL-1:0]}) * r_h2_e3;
        r_h3_dh3  <= $signed(r_h2_den[PW2-1:SL]) * r_h2_e3;
        r_h3_live <= r_h2_live;
    end

    // ---------------- H4, H5: assemble n and d ----------------
    logic signed [RW-1:0] r_h4_p1, r_h4_p2, r_h4_d, r_h5_n, r_h5_d;
    logic                 r_h4_live, r_h5_live;

    always_ff @(posedge i_clk) begin
        r_h4_p1   <= (RW'(r_h3_dh1) <<< SL) + RW'(r_h3_dl1);
        r_h4_p2   <= (RW'(r_h3_nh2) <<< SL) + RW'(r_h3_nl2);
        r_h4_d    <= (RW'(r_h3_dh3) <<< SL) + RW'(r_h3_dl3);
        r_h4_live <= r_h3_live;
        r_h5_n    <= r_h4_p1 + r_h4_p2;
        r_h5_d    <= r_h4_d;
        r_h5_live <= r_h4_live;
    end

    // ---------------- H6: 0 <= n/d <= 1 ----------------
    logic h6_ratio;

    always_comb begin
        if (r_h5_d > 0) begin
            h6_ratio = (r_h5_n >= 0) && (r_h5_n <= r_h5_d);
        end else begin
            h6_ratio = (r_h5_n <= 0) && (r_h5_n >= r_h5_d);
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= r_h5_live && h6_ratio;
    end

`ifndef NO_ASSERTIONS
    a_issue_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vpipe[0] |-> $past(r_state == ST_RUN))
        else $error("triangle read issued outside a classify walk");

    a_write_with_empty_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_vpipe == '0))
        else $error("triangle write while a walk is in flight");

    a_result_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_vpipe == '0 && !issue))
        else $error("result taken before the pipeline drained");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_TRIANGLES))
        else $error("crossing count beyond table size");
`endif
endmodule

// File: rtl/picsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module picsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: test/point_in_closed_surface_labeler_tb.sv
// Testbench for the point-in-closed-surface labeler: random and directed words, checked on the fly.
`timescale 1ns / 100ps

module point_in_closed_surface_labeler_tb;
    import picsl_pkg::*;

    localparam int NTRI     = 256;
    localparam int CBITS    = 20;
    localparam int N_ITEMS  = 1750;
    localparam int IDLE_MAX = 4000;   // classify over 256 triangles plus the longest result stall
    localparam int DRAIN_CY = 10;     // a load word has no result; let its write settle

    typedef struct {
        logic                    func;
        logic [TRI_INDEX_W-1:0]  tri_index;
        logic signed [CBITS-1:0] crd [9];   // v1x v1y v1z v2x v2y v2z v3x v3y v3z
        logic [LABEL_W-1:0]      node_label;
    } word_t;

    typedef struct {
        logic               is_inside;
        logic [LABEL_W-1:0] new_label;
        logic [CROSS_W-1:0] crossings;
    } label_t;

    // Keeps its own triangle table and registers and predicts the label of each classify word.
    class label_tracker;
        longint tx [NTRI][3];
        longint ty [NTRI][3];
        longint tz [NTRI][3];
        longint pa [NTRI];
        longint pb [NTRI];
        longint pc [NTRI];
        longint pd [NTRI];
        int unsigned tri_count;
        logic [LABEL_W-1:0] in_label;
        label_t label_q [$];
        int fails, n_loads, n_classify, n_inside;

        function new();
            tri_count = 0;
            in_label  = '0;
            fails     = 0;
            n_loads   = 0;
            n_classify = 0;
            n_inside  = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_TRIANGLE_COUNT) tri_count = val[TCOUNT_W-1:0];
            else if (idx == REG_INSIDE_LABEL) in_label = val;
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        // closed projected triangle, exact by cross-multiplication
        function bit in_tri(longint x1, longint x2, longint x3, longint xp,
                            longint y1, longint y2, longint y3, longint yp);
            longint den, num, n, d;
            den = (yp - y1) * (x3 - x2) + (x1 - xp) * (y3 - y2);
            if (den == 0) return 0;
            num = (y2 - y1) * (x3 - x2) + (x1 - x2) * (y3 - y2);
            if (den > 0 ? num < den : num > den) return 0;
            if (x3 - x2 != 0) begin
                n = (x1 - x2) * den + num * (xp - x1);
                d = den * (x3 - x2);
            end else if (y3 - y2 != 0) begin
                n = (y1 - y2) * den + num * (yp - y1);
                d = den * (y3 - y2);
            end else begin
                return 0;
            end
            if (d < 0) begin
                n = -n;
                d = -d;
            end
            return n >= 0 && n <= d;
        endfunction

        function bit ray_hits(int i, longint px, longint py, longint pz);
            longint a, b, c, num, q, xh, lim;
            a = pa[i];
            b = pb[i];
            c = pc[i];
            lim = longint'(1) << (CBITS - 1);
            if (mag(a) <= 1) return 0;             // flat to the ray
            num = a * px + b * py + c * pz + pd[i];
            if (num != 0 && ((num > 0) == (a > 0))) return 0;   // hit behind the point
            q  = (-num) / a;
            xh = px + q;
            if (xh > lim) xh = lim;
            if (xh < -lim - 1) xh = -lim - 1;
            if (mag(a) > mag(b) && mag(a) > mag(c))
                return in_tri(ty[i][0], ty[i][1], ty[i][2], py, tz[i][0], tz[i][1], tz[i][2], pz);
            if (mag(a) <= mag(b) && mag(b) > mag(c))
                return in_tri(tx[i][0], tx[i][1], tx[i][2], xh, tz[i][0], tz[i][1], tz[i][2], pz);
            return in_tri(tx[i][0], tx[i][1], tx[i][2], xh, ty[i][0], ty[i][1], ty[i][2], py);
        endfunction

        function void note_word(word_t w);
            longint v [9];
            int k, n, count;
            label_t r;
            for (int j = 0; j < 9; j++) v[j] = longint'(w.crd[j]);
            if (w.func == FUNC_LOAD) begin
                k = w.tri_index;
                n_loads++;
                for (int j = 0; j < 3; j++) begin
                    tx[k][j] = v[3*j];
                    ty[k][j] = v[3*j+1];
                    tz[k][j] = v[3*j+2];
                end
                pa[k] = v[1] * (v[5] - v[8]) - v[2] * (v[4] - v[7]) + (v[4] * v[8] - v[7] * v[5]);
                pb[k] = -(v[0] * (v[5] - v[8]) - v[2] * (v[3] - v[6])
                          + (v[3] * v[8] - v[6] * v[5]));
                pc[k] = v[0] * (v[4] - v[7]) - v[1] * (v[3] - v[6]) + (v[3] * v[7] - v[6] * v[4]);
                pd[k] = -(v[0] * (v[4] * v[8] - v[7] * v[5]) - v[1] * (v[3] * v[8] - v[6] * v[5])
                          + v[2] * (v[3] * v[7] - v[6] * v[4]));
            end else begin
                n = tri_count < NTRI ? tri_count : NTRI;
                count = 0;
                for (int i = 0; i < n; i++)
                    if (ray_hits(i, v[0], v[1], v[2])) count++;
                r.is_inside = count[0];
                r.new_label = count[0] ? in_label : w.node_label;
                r.crossings = count[CROSS_W-1:0];
                n_classify++;
                if (count[0]) n_inside++;
                label_q.push_back(r);
            end
        endfunction

        function void check_result(logic ins, logic [LABEL_W-1:0] lbl, logic [CROSS_W-1:0] crs);
            label_t e;
            if (label_q.size() == 0) begin
                $error("result with no classify word pending: is_inside=%0d new_label=%0h",
                       ins, lbl);
                fails++;
                return;
            end
            e = label_q.pop_front();
            if (ins !== e.is_inside) begin
                $error("is_inside: expected %0d, got %0d", e.is_inside, ins);
                fails++;
            end
            if (lbl !== e.new_label) begin
                $error("new_label: expected %0h, got %0h", e.new_label, lbl);
                fails++;
            end
            if (crs !== e.crossings) begin
                $error("crossings: expected %0d, got %0d", e.crossings, crs);
                fails++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    picsl_in_if #(.COORD_BITS(CBITS)) in_ch ();
    picsl_out_if                      res_ch ();
    picsl_cfg_if                      cfg_ch ();

    point_in_closed_surface_labeler #(
        .MAX_TRIANGLES(NTRI),
        .COORD_BITS   (CBITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    label_tracker labels = new();

    int sent = 0;
    int burst_left = 0;
    int gap_max = 4;
    int stall_mode = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int cx, cy, cz, cr;   // current cloud: center and radius of triangles and points

    // Drive every input to a known value from time zero.
    initial begin
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_LOAD;
        in_ch.tri_index = '0;
        in_ch.v1x = '0; in_ch.v1y = '0; in_ch.v1z = '0;
        in_ch.v2x = '0; in_ch.v2y = '0; in_ch.v2z = '0;
        in_ch.v3x = '0; in_ch.v3y = '0; in_ch.v3z = '0;
        in_ch.node_label = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.idx = REG_TRIANGLE_COUNT;
        cfg_ch.data = '0;
    end

    // Receiver: check each accepted result word, then pick the next ready per the stall mode.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            labels.check_result(res_ch.is_inside, res_ch.new_label, res_ch.crossings);
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (stall_mode == 0) begin
            res_ch.ready <= 1'b1;
        end else if (stall_mode == 1) begin
            res_ch.ready <= 1'($urandom_range(0, 1));
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 20);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no handshake on any channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("timeout: no handshake for %0d cycles", IDLE_MAX);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Pick a new cloud; sometimes push it against the edge of the coordinate range.
    function automatic void pick_cloud();
        int lim;
        case ($urandom_range(0, 2))
            0: cr = 3;
            1: cr = 64;
            default: cr = 2000;
        endcase
        lim = 524287 - cr;
        cx = rnd(-lim, lim);
        cy = rnd(-lim, lim);
        cz = rnd(-lim, lim);
        if ($urandom_range(0, 4) == 0) cx = $urandom_range(0, 1) ? lim : -lim;
        if ($urandom_range(0, 4) == 0) cy = $urandom_range(0, 1) ? lim : -lim;
    endfunction

    function automatic word_t mk_word(logic func, int idx, int c [9], int lbl);
        word_t w;
        w.func = func;
        w.tri_index = TRI_INDEX_W'(idx);
        for (int j = 0; j < 9; j++) w.crd[j] = CBITS'(c[j]);
        w.node_label = LABEL_W'(lbl);
        return w;
    endfunction

    // Random triangle from the cloud, or a random point in it when classifying.
    function automatic word_t cloud_word(logic func, int idx);
        int c [9];
        for (int j = 0; j < 9; j++)
            c[j] = (j % 3 == 0 ? cx : (j % 3 == 1 ? cy : cz)) + rnd(-cr, cr);
        if (func == FUNC_CLASSIFY)
            for (int j = 3; j < 9; j++) c[j] = int'($urandom);   // unused fields: noise
        return mk_word(func, idx, c, $urandom_range(0, 65535));
    endfunction

    // Present one word and hold it until accepted; then continue the burst or open a gap.
    task automatic send_word(word_t w);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.func <= w.func;
        in_ch.tri_index <= w.tri_index;
        in_ch.v1x <= w.crd[0]; in_ch.v1y <= w.crd[1]; in_ch.v1z <= w.crd[2];
        in_ch.v2x <= w.crd[3]; in_ch.v2y <= w.crd[4]; in_ch.v2z <= w.crd[5];
        in_ch.v3x <= w.crd[6]; in_ch.v3y <= w.crd[7]; in_ch.v3z <= w.crd[8];
        in_ch.node_label <= w.node_label;
        do @(posedge i_clk); while (!in_ch.ready);
        labels.note_word(w);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = rnd(0, 12);
            gap = rnd(0, gap_max);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid and hold off until every pending label has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (labels.label_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CY) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx <= idx;
        cfg_ch.data <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!cfg_ch.ready);
        labels.set_reg(idx, CFG_DATA_W'(val));
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic classify(int x, int y, int z, int lbl);
        int c [9];
        c = '{x, y, z, 0, 0, 0, 0, 0, 0};
        send_word(mk_word(FUNC_CLASSIFY, 0, c, lbl));
    endtask

    initial begin
        int c [9];
        int cnt, nload, ncls;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole table first so no classify ever reads an unwritten entry.
        pick_cloud();
        for (int i = 0; i < NTRI; i++) send_word(cloud_word(FUNC_LOAD, i));
        drain();

        // Directed: one triangle per special case, then points aimed at them.
        write_reg(REG_TRIANGLE_COUNT, 4);
        write_reg(REG_INSIDE_LABEL, 16'hFFFF);
        gap_max = 0;
        c = '{2560, 0, 0, 2560, 25600, 0, 2560, 0, 25600};        // facing the ray, yz projection
        send_word(mk_word(FUNC_LOAD, 0, c, 0));
        c = '{0, 0, 0, 25600, 12800, 0, 0, 12800, 25600};         // tilted, b dominates
        send_word(mk_word(FUNC_LOAD, 1, c, 0));
        c = '{-524288, 7, -524288, 524287, 7, 0, 0, 7, 524287};    // flat to the ray, extremes
        send_word(mk_word(FUNC_LOAD, 2, c, 0));
        c = '{0, 0, 0, 1, 1, 1, 2, 2, 2};                          // zero-area triangle
        send_word(mk_word(FUNC_LOAD, 3, c, 0));
        classify(0, 2560, 2560, 16'h1234);       // in front: crossing
        classify(5120, 2560, 2560, 16'h0000);    // behind the point
        classify(2560, 2560, 2560, 16'hFFFF);    // on the plane, t equal to zero
        classify(0, 0, 0, 16'h00FF);             // at a vertex
        classify(0, 12800, 12800, 16'hFF00);     // on an edge
        classify(0, 7, 100, 16'h5A5A);           // in the flat triangle's plane
        classify(-524288, 2560, 2560, 16'hA5A5); // far left, hit x far away
        classify(524287, -524288, 524287, 16'h0001);
        classify(-524288, 524287, -524288, 16'h8000);
        drain();
        write_reg(REG_TRIANGLE_COUNT, 0);        // no triangles: label passes through
        write_reg(REG_INSIDE_LABEL, 0);
        classify(0, 2560, 2560, 16'hFFFF);
        drain();
        write_reg(REG_TRIANGLE_COUNT, NTRI);     // full table
        write_reg(REG_INSIDE_LABEL, 16'h8001);
        classify(0, 2560, 2560, 16'h7FFE);
        send_word(cloud_word(FUNC_CLASSIFY, 0));
        drain();

        // Random phases: new cloud, registers, flow pattern, loads and queries.
        while (sent < N_ITEMS) begin
            pick_cloud();
            case ($urandom_range(0, 9))
                0: cnt = 0;
                1: cnt = NTRI;
                default: cnt = rnd(1, 32);
            endcase
            write_reg(REG_TRIANGLE_COUNT, cnt);
            case ($urandom_range(0, 3))
                0: write_reg(REG_INSIDE_LABEL, 0);
                1: write_reg(REG_INSIDE_LABEL, 16'hFFFF);
                default: write_reg(REG_INSIDE_LABEL, $urandom_range(0, 65535));
            endcase
            stall_mode = $urandom_range(0, 2);
            gap_max = $urandom_range(0, 1) ? 0 : 8;
            nload = cnt == 0 ? 2 : rnd(1, cnt > 32 ? 32 : cnt);
            for (int i = 0; i < nload; i++)
                send_word(cloud_word(FUNC_LOAD, $urandom_range(0, cnt > 0 ? cnt - 1 : 255)));
            ncls = cnt == NTRI ? rnd(4, 10) : rnd(8, 25);
            for (int i = 0; i < ncls; i++) begin
                if ($urandom_range(0, 5) == 0)
                    send_word(cloud_word(FUNC_LOAD, $urandom_range(0, 255)));
                send_word(cloud_word(FUNC_CLASSIFY, 0));
            end
            drain();
        end

        stall_mode = 0;
        drain();
        repeat (300) @(posedge i_clk);
        if (labels.label_q.size() != 0) begin
            $error("%0d labels never came back", labels.label_q.size());
            labels.fails++;
        end
        $display("covered %0d triangle loads and %0d point queries, %0d found inside",
                 labels.n_loads, labels.n_classify, labels.n_inside);
        $display("over random clouds of three sizes, counts 0 to %0d, with sender gaps and stalls",
                 NTRI);
        if (labels.fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/picsl_pkg.sv
rtl/picsl_ifs.sv
rtl/picsl_ram.sv
rtl/point_in_closed_surface_labeler.sv
test/point_in_closed_surface_labeler_tb.sv
